// ----- rtl/hss_pkg.sv -----
package hss_pkg;

	// Command codes carried in the func field.
	localparam logic [1:0] FUNC_UPDATE = 2'd0;
	localparam logic [1:0] FUNC_MOVE   = 2'd1;
	localparam logic [1:0] FUNC_STOP   = 2'd2;

	// Largest step count the 31-bit counter can hold.
	localparam logic [30:0] STEPS_MAX = 31'h7FFF_FFFF;

	// Phase values where a forward or a reverse move starts.
	localparam logic [2:0] PHASE_FWD_START = 3'd0;
	localparam logic [2:0] PHASE_REV_START = 3'd7;

	// One command beat.
	typedef struct packed {
		logic [1:0]         func;
		logic [31:0]        now_us;
		logic signed [31:0] move_steps;
		logic [31:0]        move_interval;
		logic               release_coils;
	} cmd_item_t;

	// One status beat.
	typedef struct packed {
		logic [3:0]  coils;
		logic        stepped;
		logic        busy_res;
		logic [30:0] steps_left;
	} res_item_t;

	// Half-step coil pattern for each phase, IN1 on bit 0 through IN4 on bit 3.
	function automatic logic [3:0] phase_coils(input logic [2:0] phase);
		logic [3:0] pattern;
		case (phase)
			3'd0:    pattern = 4'h1;
			3'd1:    pattern = 4'h3;
			3'd2:    pattern = 4'h2;
			3'd3:    pattern = 4'h6;
			3'd4:    pattern = 4'h4;
			3'd5:    pattern = 4'hC;
			3'd6:    pattern = 4'h8;
			default: pattern = 4'h9;
		endcase
		return pattern;
	endfunction

endpackage

// ----- rtl/hss_if.sv -----
// Command channel: valid/ready handshake with one command item per beat.
interface hss_cmd_if;
	logic                  valid;
	logic                  ready;
	hss_pkg::cmd_item_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// Status channel: valid/ready handshake with one status item per beat.
interface hss_res_if;
	logic                  valid;
	logic                  ready;
	hss_pkg::res_item_t    data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/hss_in_reg.sv -----
// Input register: captures one command beat and holds it until the core takes it.
module hss_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	hss_cmd_if.sink            cmd,
	input  logic               advance,
	output logic               valid_s1,
	output hss_pkg::cmd_item_t item_s1
);

	logic load;

	// A new beat is taken when the register is empty or drains this cycle.
	assign cmd.ready = !valid_s1 || advance;
	assign load      = cmd.valid && cmd.ready;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= cmd.data;
		end
	end

endmodule

// ----- rtl/hss_core.sv -----
// Sequencer core: applies one command to the motor state and registers the status.
module hss_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  hss_pkg::cmd_item_t item_s1,
	output logic               advance,
	hss_res_if.source          res
);

	// Motor state.
	logic [3:0]  coil_q;
	logic [2:0]  phase_q;
	logic        reverse_q;
	logic [30:0] remaining_q;
	logic        first_q;
	logic [31:0] interval_q;
	logic [31:0] due_q;

	// Next-state values.
	logic [3:0]  coil_d;
	logic [2:0]  phase_d;
	logic        reverse_d;
	logic [30:0] remaining_d;
	logic        first_d;
	logic [31:0] interval_d;
	logic [31:0] due_d;
	logic        stepped_d;

	// Helpers.
	logic [31:0] diff;
	logic        due;
	logic        neg;
	logic [31:0] mag;
	logic        fire;

	// Output register.
	logic                 res_valid_s2;
	hss_pkg::res_item_t   res_item_s2;

	// The stage moves when the result register is free or being emptied.
	assign advance   = !res_valid_s2 || res.ready;
	assign fire      = valid_s1 && advance;
	assign res.valid = res_valid_s2;
	assign res.data  = res_item_s2;

	// Due test: the wrapped difference now minus due time is not negative.
	assign diff = item_s1.now_us - due_q;
	assign due  = first_q || !diff[31];

	// Magnitude of the requested count; only the most negative count overflows.
	assign neg = item_s1.move_steps[31];
	assign mag = neg ? (32'd0 - item_s1.move_steps) : item_s1.move_steps;

	// Command decode and state update.
	always_comb begin
		coil_d      = coil_q;
		phase_d     = phase_q;
		reverse_d   = reverse_q;
		remaining_d = remaining_q;
		first_d     = first_q;
		interval_d  = interval_q;
		due_d       = due_q;
		stepped_d   = 1'b0;
		unique case (item_s1.func)
			hss_pkg::FUNC_UPDATE: begin
				if ((remaining_q != '0) && due) begin
					coil_d      = hss_pkg::phase_coils(phase_q);
					remaining_d = remaining_q - 31'd1;
					first_d     = 1'b0;
					due_d       = item_s1.now_us + interval_q;
					phase_d     = reverse_q ? (phase_q - 3'd1) : (phase_q + 3'd1);
					stepped_d   = 1'b1;
				end
			end
			hss_pkg::FUNC_MOVE: begin
				if (item_s1.move_steps == '0) begin
					remaining_d = '0;
					first_d     = 1'b0;
				end else begin
					reverse_d   = neg;
					remaining_d = mag[31] ? hss_pkg::STEPS_MAX : mag[30:0];
					interval_d  = (item_s1.move_interval == '0) ? 32'd1
					                                            : item_s1.move_interval;
					phase_d     = neg ? hss_pkg::PHASE_REV_START : hss_pkg::PHASE_FWD_START;
					first_d     = 1'b1;
				end
			end
			hss_pkg::FUNC_STOP: begin
				remaining_d = '0;
				first_d     = 1'b0;
				if (item_s1.release_coils) begin
					coil_d = 4'h0;
				end
			end
			default: begin
				// Unused code: the state is left as it is, and the status reports it with no step.
			end
		endcase
	end

	// Control state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_q       <= 4'h0;
			phase_q      <= hss_pkg::PHASE_FWD_START;
			reverse_q    <= 1'b0;
			remaining_q  <= '0;
			first_q      <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				coil_q      <= coil_d;
				phase_q     <= phase_d;
				reverse_q   <= reverse_d;
				remaining_q <= remaining_d;
				first_q     <= first_d;
			end
			if (advance) begin
				res_valid_s2 <= valid_s1;
			end
		end
	end

	// Timing registers and the status payload; none of them needs a reset.
	always_ff @(posedge clk) begin
		if (fire) begin
			interval_q             <= interval_d;
			due_q                  <= due_d;
			res_item_s2.coils      <= coil_d;
			res_item_s2.stepped    <= stepped_d;
			res_item_s2.busy_res   <= (remaining_d != '0);
			res_item_s2.steps_left <= remaining_d;
		end
	end

endmodule

// ----- rtl/half_step_stepper_sequencer.sv -----
// Half-step sequencer for a four-coil unipolar stepper. Each command beat (time
// update, move or stop) returns exactly one status beat with the coil drive bits,
// a stepped flag, a busy flag and the remaining half-step count. The block takes
// one command per clock while the status channel does not back up. An accepted
// command is held in the input register; the state update then loads the status
// register, from which the status beat is offered.
// Back-pressure on the status channel stalls the command channel only once both
// registers are full.
module half_step_stepper_sequencer (
	input  logic       clk,
	input  logic       arst_n,
	hss_cmd_if.sink    cmd,
	hss_res_if.source  res
);

	logic               advance;
	logic               valid_s1;
	hss_pkg::cmd_item_t item_s1;

	// Command input register.
	hss_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// State update and status register.
	hss_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.advance  (advance),
		.res      (res)
	);

endmodule

// ----- test/hss_status_checker.sv -----
module hss_status_checker (
	input  logic clk,
	input  logic arst_n,
	hss_cmd_if   cmd,
	hss_res_if   res,
	output int   fail_cnt,
	output int   pending
);

	// Coil drive per phase, four bits per phase with phase 0 in the low nibble.
	localparam logic [31:0] HALF_STEP_COILS = 32'h9_8_C_4_6_2_3_1;

	// Shadow copy of the sequencer state.
	logic [3:0]  coil_drive;
	logic [2:0]  phase_idx;
	logic        run_reverse;
	logic [30:0] steps_remaining;
	logic [31:0] step_period;
	logic [31:0] next_due;
	logic        first_step_owed;

	hss_pkg::res_item_t status_q[$];
	hss_pkg::res_item_t want;

	// Applies one command to the shadow state and returns the status it must produce.
	function automatic hss_pkg::res_item_t advance_sequencer(input hss_pkg::cmd_item_t c);
		hss_pkg::res_item_t r;
		logic [31:0]        lag;
		logic [31:0]        mag;
		logic               fired;
		fired = 1'b0;
		case (c.func)
			hss_pkg::FUNC_UPDATE: begin
				if (steps_remaining != '0) begin
					lag = c.now_us - next_due;
					if (first_step_owed || !lag[31]) begin
						coil_drive      = HALF_STEP_COILS[4 * phase_idx +: 4];
						steps_remaining = steps_remaining - 31'd1;
						first_step_owed = 1'b0;
						next_due        = c.now_us + step_period;
						phase_idx       = run_reverse ? phase_idx - 3'd1 : phase_idx + 3'd1;
						fired           = 1'b1;
					end
				end
			end
			hss_pkg::FUNC_MOVE: begin
				if (c.move_steps == 32'sd0) begin
					steps_remaining = '0;
					first_step_owed = 1'b0;
				end else begin
					mag = c.move_steps[31] ? 32'd0 - c.move_steps : c.move_steps;
					// A count of minus two to the 31st does not fit and saturates.
					if (mag > {1'b0, hss_pkg::STEPS_MAX}) begin
						mag = {1'b0, hss_pkg::STEPS_MAX};
					end
					run_reverse     = c.move_steps[31];
					steps_remaining = mag[30:0];
					step_period     = (c.move_interval == '0) ? 32'd1 : c.move_interval;
					phase_idx       = c.move_steps[31] ? hss_pkg::PHASE_REV_START
					                                   : hss_pkg::PHASE_FWD_START;
					first_step_owed = 1'b1;
				end
			end
			hss_pkg::FUNC_STOP: begin
				steps_remaining = '0;
				first_step_owed = 1'b0;
				if (c.release_coils) begin
					coil_drive = '0;
				end
			end
			default: begin
			end
		endcase
		r.coils      = coil_drive;
		r.stepped    = fired;
		r.busy_res   = (steps_remaining != '0);
		r.steps_left = steps_remaining;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_cnt++;
		end
	endtask

	// Compare each status beat with the oldest expectation, then predict new commands.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_drive      = '0;
			phase_idx       = '0;
			run_reverse     = 1'b0;
			steps_remaining = '0;
			step_period     = '0;
			next_due        = '0;
			first_step_owed = 1'b0;
			status_q.delete();
			pending         = 0;
			fail_cnt        = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (status_q.size() == 0) begin
					$error("status beat with nothing expected: %p", res.data);
					fail_cnt++;
				end else begin
					want = status_q.pop_front();
					check_field("coils", 32'(want.coils), 32'(res.data.coils));
					check_field("stepped", 32'(want.stepped), 32'(res.data.stepped));
					check_field("busy_res", 32'(want.busy_res), 32'(res.data.busy_res));
					check_field("steps_left", 32'(want.steps_left),
						32'(res.data.steps_left));
				end
			end
			if (cmd.valid && cmd.ready) begin
				status_q.push_back(advance_sequencer(cmd.data));
			end
			pending = status_q.size();
		end
	end

endmodule

// ----- test/tb_half_step_stepper_sequencer.sv -----
module tb_half_step_stepper_sequencer;

	// Selector value the block must ignore.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	int          fail_cnt;
	int          pending;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	logic        hold_req = 1'b0;
	logic        hold_taken;
	int          hold_left;
	logic [31:0] clock_us;

	hss_cmd_if cmd ();
	hss_res_if res ();

	half_step_stepper_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.res    (res)
	);

	hss_status_checker i_status_chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res      (res),
		.fail_cnt (fail_cnt),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// Status side: random stalls, plus one long hold-off so the block backs up.
	initial begin
		res.ready  = 1'b0;
		hold_taken = 1'b0;
		hold_left  = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left  = 60;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	function automatic hss_pkg::cmd_item_t make_cmd(input logic [1:0] f,
			input logic [31:0] t, input logic [31:0] s, input logic [31:0] ivl,
			input logic rel);
		hss_pkg::cmd_item_t c;
		c.func          = f;
		c.now_us        = t;
		c.move_steps    = s;
		c.move_interval = ivl;
		c.release_coils = rel;
		return c;
	endfunction

	// Offers one command beat, with random gaps before it, and returns once accepted.
	task automatic send_cmd(input hss_pkg::cmd_item_t c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.data  <= c;
		@(posedge clk);
		while (!cmd.ready) begin
			@(posedge clk);
		end
	endtask

	// Mostly moves walked through by time updates, with stops, cancels and noise mixed in.
	task automatic random_traffic(input int n_items);
		int                 sent;
		int                 burst;
		int                 mag;
		int                 pick;
		logic signed [31:0] steps;
		logic [31:0]        ivl;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_cmd(make_cmd(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
					1'($urandom_range(0, 1))));
				sent++;
			end else if (pick < 16) begin
				send_cmd(make_cmd(hss_pkg::FUNC_STOP, clock_us, $urandom, $urandom,
					1'($urandom_range(0, 1))));
				sent++;
			end else begin
				mag   = $urandom_range(1, 12);
				steps = $urandom_range(0, 1) ? -mag : mag;
				if ($urandom_range(0, 19) == 0) begin
					steps = $urandom;
				end
				ivl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
				send_cmd(make_cmd(hss_pkg::FUNC_MOVE, $urandom, steps, ivl,
					1'($urandom_range(0, 1))));
				sent++;
				burst = mag + $urandom_range(0, 4);
				for (int k = 0; k < burst && sent < n_items; k++) begin
					pick = $urandom_range(0, 99);
					if (pick < 5) begin
						clock_us = clock_us - $urandom_range(1, 50);
					end else if (pick < 10) begin
						clock_us = clock_us + $urandom;
					end else begin
						clock_us = clock_us + $urandom_range(0, 60);
					end
					if (pick >= 97) begin
						// Cancel the move part way with a zero count.
						send_cmd(make_cmd(hss_pkg::FUNC_MOVE, clock_us, 32'd0, $urandom,
							1'b0));
						sent++;
						break;
					end
					send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, clock_us, $urandom, $urandom,
						1'($urandom_range(0, 1))));
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd.valid = 1'b0;
		cmd.data  = '0;
		clock_us  = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Idle update, ignored selector and a stop with nothing running.
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd0, '0, '0, 1'b0));
		send_cmd(make_cmd(FUNC_UNUSED, '1, '1, '1, 1'b1));
		send_cmd(make_cmd(hss_pkg::FUNC_STOP, '0, '0, '0, 1'b0));

		// Forward move with zero interval: first step at once, then one per microsecond.
		send_cmd(make_cmd(hss_pkg::FUNC_MOVE, 32'd0, 32'd3, 32'd0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd100, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd100, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd101, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd102, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd200, '0, '0, 1'b0));

		// Reverse move across the wrap of the microsecond clock.
		send_cmd(make_cmd(hss_pkg::FUNC_MOVE, 32'd0, -32'sd2, 32'd5, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'hFFFF_FFFE, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd3, '0, '0, 1'b0));

		// Most negative count saturates; the due test at half the clock range either way.
		send_cmd(make_cmd(hss_pkg::FUNC_MOVE, 32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd10, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'h8000_0009, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'h8000_0008, '0, '0, 1'b0));

		// Zero count cancels but keeps the coils.
		send_cmd(make_cmd(hss_pkg::FUNC_MOVE, 32'd0, 32'd0, 32'd7, 1'b1));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'h9000_0000, '0, '0, 1'b0));

		// Largest count, then stop with release.
		send_cmd(make_cmd(hss_pkg::FUNC_MOVE, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd50, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_STOP, '0, '0, '0, 1'b1));
		send_cmd(make_cmd(FUNC_UNUSED, '0, '0, '0, 1'b0));
		send_cmd(make_cmd(hss_pkg::FUNC_UPDATE, 32'd60, '0, '0, 1'b0));

		// Random phases: no idling first, with the long status hold-off, then the gap mixes.
		hold_req <= 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct  = 72;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct <= 72;
				end
				default: begin
					send_idle_pct  = 32;
					recv_stall_pct <= 32;
				end
			endcase
			random_traffic(100);
		end
		cmd.valid <= 1'b0;

		// Drain the outstanding status beats, then allow for the pipeline.
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- half_step_stepper_sequencer.f -----
rtl/hss_pkg.sv
rtl/hss_if.sv
rtl/hss_in_reg.sv
rtl/hss_core.sv
rtl/half_step_stepper_sequencer.sv
test/hss_status_checker.sv
test/tb_half_step_stepper_sequencer.sv
